>>> rtl/core/sha1_pkg.sv
package sha1_pkg;

  // default depth of the op queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // command codes of an input item
  localparam logic [1:0] CMD_ABSORB        = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] CMD_FINISH        = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // classified op handed from front to back
  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic [7:0] data_byte;
  } op_t;

  // control from back to the round engine
  typedef struct packed {
    logic start;
    logic reinit;
  } cmp_ctl_t;

  typedef logic [4:0][31:0] chain_t;

  localparam chain_t CHAIN_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // round counter marks
  localparam logic [6:0] RND_PHASE_1 = 7'd20;
  localparam logic [6:0] RND_PHASE_2 = 7'd40;
  localparam logic [6:0] RND_PHASE_3 = 7'd60;
  localparam logic [6:0] RND_FINAL   = 7'd80;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LEN_FILL      = 6'd56;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [2:0] LEN_LAST      = 3'd7;
  localparam logic [2:0] WORD_IDX_LAST = 3'd4;

endpackage

>>> rtl/core/sha1_front.sv
module sha1_front import sha1_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_stall,
  input  msg_t msg,
  output logic op_valid,
  output op_t  op,
  input  logic op_full
);

  logic accept;
  logic keep;
  op_t  op_cls;

  assign msg_stall = op_valid && op_full;
  assign accept    = msg_valid && !msg_stall;

  // classify the command, undefined codes are dropped here
  always_comb begin
    op_cls.data_byte = msg.data_byte;
    keep             = 1'b1;
    unique case (msg.command)
      CMD_ABSORB: begin
        op_cls.absorb = 1'b1;
        op_cls.finish = 1'b0;
      end
      CMD_ABSORB_FINISH: begin
        op_cls.absorb = 1'b1;
        op_cls.finish = 1'b1;
      end
      CMD_FINISH: begin
        op_cls.absorb = 1'b0;
        op_cls.finish = 1'b1;
      end
      default: begin
        op_cls.absorb = 1'b0;
        op_cls.finish = 1'b0;
        keep          = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      op_valid <= keep;
    end else if (op_valid && !op_full) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_cls;
    end
  end

endmodule

>>> rtl/core/sha1_queue.sv
module sha1_queue import sha1_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic head_valid,
  output op_t  head,
  input  logic pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_do;
  logic          pop_do;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign push_do    = push && !full;
  assign pop_do     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_do) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_do) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_do && !pop_do) begin
        count <= count + 1'b1;
      end else if (pop_do && !push_do) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_do) begin
      mem[wr_ptr] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count past depth");

endmodule

>>> rtl/core/sha1_compress.sv
module sha1_round_engine import sha1_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmp_ctl_t     ctl,
  input  logic [511:0] block,
  output logic         busy,
  output chain_t       chain
);

  logic [511:0] win;
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   rnd;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;
  logic [31:0]  f;
  logic [31:0]  k;
  logic [31:0]  sum;

  // schedule window: word 0 at the top is w[t]
  assign w_mix = win[95:64] ^ win[255:224] ^ win[447:416] ^ win[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (rnd < RND_PHASE_1) begin
      f = (b & c) | (~b & d);
      k = K_0;
    end else if (rnd < RND_PHASE_2) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (rnd < RND_PHASE_3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
  end

  assign sum = {a[26:0], a[31:27]} + f + e + k + win[511:480];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      rnd   <= '0;
      chain <= CHAIN_IV;
    end else begin
      if (ctl.reinit) begin
        chain <= CHAIN_IV;
      end
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        if (rnd == RND_FINAL) begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          busy     <= 1'b0;
        end else begin
          rnd <= rnd + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      win <= block;
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      e   <= chain[4];
    end else if (busy && rnd != RND_FINAL) begin
      win <= {win[479:0], w_new};
      a   <= sum;
      b   <= a;
      c   <= {b[1:0], b[31:2]};
      d   <= c;
      e   <= d;
    end
  end

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    busy && rnd == RND_FINAL && !ctl.start |=> !busy)
    else $error("round engine did not finish after last round");

  a_reinit_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.reinit |-> !busy && !ctl.start)
    else $error("chain reinit while compressing");

endmodule

>>> rtl/core/sha1_back.sv
module sha1_back import sha1_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  op_t          op,
  output logic         op_pop,
  output cmp_ctl_t     cmp_ctl,
  output logic [511:0] cmp_block,
  input  logic         cmp_busy,
  input  chain_t       chain,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_t      digest
);

  typedef enum logic [5:0] {
    ST_RUN  = 6'b000001,
    ST_MARK = 6'b000010,
    ST_ZERO = 6'b000100,
    ST_LEN  = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_t;

  back_state_t  state;
  back_state_t  state_next;
  logic [5:0]   fill;
  logic [60:0]  msg_bytes;
  logic [511:0] blk;
  logic [511:0] blk_next;
  logic [63:0]  len_sr;
  logic [2:0]   len_cnt;
  logic [2:0]   word_idx;
  logic         blocked;
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic         emit;
  logic         emit_last;

  // a byte that closes a block must wait for the round engine
  assign blocked = (fill == FILL_LAST) && cmp_busy;

  always_comb begin
    state_next = state;
    shift_en   = 1'b0;
    shift_byte = op.data_byte;
    op_pop     = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (op_valid) begin
          if (op.absorb) begin
            if (!blocked) begin
              op_pop   = 1'b1;
              shift_en = 1'b1;
              if (op.finish) begin
                state_next = ST_MARK;
              end
            end
          end else begin
            op_pop = 1'b1;
            if (op.finish) begin
              state_next = ST_MARK;
            end
          end
        end
      end
      ST_MARK: begin
        shift_byte = PAD_MARK;
        if (!blocked) begin
          shift_en   = 1'b1;
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        shift_byte = 8'h00;
        if (fill == LEN_FILL) begin
          state_next = ST_LEN;
        end else if (!blocked) begin
          shift_en = 1'b1;
        end
      end
      ST_LEN: begin
        shift_byte = len_sr[63:56];
        if (!blocked) begin
          shift_en = 1'b1;
          if (len_cnt == LEN_LAST) begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (!cmp_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        emit = !digest_valid || !digest_stall;
        if (emit && word_idx == WORD_IDX_LAST) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign emit_last      = emit && (word_idx == WORD_IDX_LAST);
  assign blk_next       = {blk[503:0], shift_byte};
  assign cmp_block      = blk_next;
  assign cmp_ctl.start  = shift_en && (fill == FILL_LAST);
  assign cmp_ctl.reinit = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      fill         <= '0;
      msg_bytes    <= '0;
      len_cnt      <= '0;
      word_idx     <= '0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (shift_en) begin
        fill <= fill + 1'b1;
      end
      if (state == ST_RUN && shift_en) begin
        msg_bytes <= msg_bytes + 1'b1;
      end else if (emit_last) begin
        msg_bytes <= '0;
      end
      if (state == ST_MARK) begin
        len_cnt <= '0;
      end else if (state == ST_LEN && shift_en) begin
        len_cnt <= len_cnt + 1'b1;
      end
      if (emit) begin
        digest_valid <= 1'b1;
        word_idx     <= emit_last ? '0 : word_idx + 1'b1;
      end else if (digest_valid && !digest_stall) begin
        digest_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      blk <= blk_next;
    end
    if (state == ST_MARK) begin
      len_sr <= {msg_bytes, 3'b000};
    end else if (state == ST_LEN && shift_en) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
    if (emit) begin
      digest.digest_word <= chain[word_idx];
      digest.word_index  <= word_idx;
      digest.last_word   <= emit_last;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmp_ctl.start |-> !cmp_busy)
    else $error("block handed to busy round engine");

  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> fill == '0 && !cmp_busy)
    else $error("digest read with partial block or busy engine");

  a_pad_no_pop: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> !op_pop)
    else $error("op taken during padding or output");

endmodule

>>> rtl/core/sha1_hash_engine.sv
// SHA-1 engine taking one message byte per item. Each item carries a
// command: absorb the byte, absorb the byte and finish, or finish with no
// byte (the fourth code is dropped without effect). Finishing pads the
// message with the 0x80 marker, zero fill and the 64-bit big-endian bit
// length, then sends the five digest words on the digest channel, word 0
// first, last_word set on word 4, and the engine is ready for a new
// message. Bytes are taken at one per cycle, except while the back end
// pads or sends the digest or a closing byte waits, into a 64-byte shift
// buffer; a full block is copied into the round engine, which runs one
// round per cycle and stays busy through 80 rounds and the chaining add.
// The next block is collected while the current one is compressed and is
// handed over as soon as the engine goes idle, so intake is bounded by
// the compression. A byte that would close a block while the engine is
// still busy waits for it. Finishing shifts in the padding bytes (9 to 72
// bytes, one or two blocks), waits for the final compression and then
// sends the digest words whenever the digest channel is not stalled. An
// item passes a front register and a short op queue before the back end
// works on it, so the message side can keep handing over items, until
// both are full, while the back end pads or waits on the digest side.
module sha1_hash_engine import sha1_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  // message bytes and commands
  input  logic    msg_valid,
  output logic    msg_stall,
  input  msg_t    msg,
  // digest words
  output logic    digest_valid,
  input  logic    digest_stall,
  output digest_t digest
);

  // front register to queue
  logic         fr_valid;
  op_t          fr_op;
  logic         q_full;

  // queue to back end
  logic         q_valid;
  op_t          q_head;
  logic         q_pop;

  // back end to round engine
  cmp_ctl_t     cmp_ctl;
  logic [511:0] cmp_block;
  logic         cmp_busy;
  chain_t       chain;

  sha1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .op_valid  (fr_valid),
    .op        (fr_op),
    .op_full   (q_full)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_op    (fr_op),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  // padding, block buffer and digest output
  sha1_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_valid),
    .op           (q_head),
    .op_pop       (q_pop),
    .cmp_ctl      (cmp_ctl),
    .cmp_block    (cmp_block),
    .cmp_busy     (cmp_busy),
    .chain        (chain),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  // 80-round compression and chaining value
  sha1_round_engine u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cmp_ctl),
    .block (cmp_block),
    .busy  (cmp_busy),
    .chain (chain)
  );

endmodule

>>> bench/sha1_hash_engine_test.sv
`timescale 1ns / 100ps

module sha1_hash_engine_test;
  import sha1_pkg::*;

  // the fourth command code has no name in the package; the engine drops it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // cycles with no item moving on either channel before the run is called hung;
  // the worst finish is the padding bytes plus two compressions behind one still
  // in flight, all of it behind a stalled digest side
  localparam int QUIET_LIMIT = 10000;

  // cycles allowed after the last digest word for any stray output
  localparam int DRAIN_CYCLES = 400;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    msg_valid = 1'b0;
  logic    msg_stall;
  msg_t    msg = '0;
  logic    digest_valid;
  logic    digest_stall = 1'b0;
  digest_t digest;

  // running hash state of the predictor
  logic [31:0] sha_chain [5];
  logic [7:0]  sha_block [64];
  int unsigned sha_fill;
  logic [60:0] sha_bytes;

  // digest words predicted but not yet seen, oldest first
  digest_t digest_words_due [$];

  // flow-control knobs, percent per cycle
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  int error_count = 0;
  int message_items = 0;
  int ignored_items = 0;
  int messages_sent = 0;
  int words_checked = 0;
  int quiet_cycles = 0;

  sha1_hash_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: plain sha-1 over one byte per item
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void load_initial_chain();
    sha_chain[0] = 32'h67452301;
    sha_chain[1] = 32'hEFCDAB89;
    sha_chain[2] = 32'h98BADCFE;
    sha_chain[3] = 32'h10325476;
    sha_chain[4] = 32'hC3D2E1F0;
  endfunction

  // 80 rounds over the 64-byte buffer, folded into the chaining value
  function automatic void compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++)
      sched[t] = {sha_block[4*t], sha_block[4*t+1], sha_block[4*t+2], sha_block[4*t+3]};
    for (int t = 16; t < 80; t++)
      sched[t] = rol32(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      sum = rol32(a, 5) + f + e + k + sched[t];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = sum;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  function automatic void absorb_byte(logic [7:0] data);
    sha_block[sha_fill] = data;
    sha_fill++;
    sha_bytes++;
    if (sha_fill == 64) begin
      compress_block();
      sha_fill = 0;
    end
  endfunction

  // pad, compress, queue the five digest words and start a fresh message
  function automatic void finish_message();
    logic [63:0] bit_len;
    digest_t word;
    bit_len = {sha_bytes, 3'b000};
    sha_block[sha_fill] = PAD_MARK;
    sha_fill++;
    // marker landed in the length field: close this block, length goes alone
    if (sha_fill > 56) begin
      for (int i = sha_fill; i < 64; i++)
        sha_block[i] = 8'h00;
      compress_block();
      sha_fill = 0;
    end
    for (int i = sha_fill; i < 56; i++)
      sha_block[i] = 8'h00;
    for (int i = 0; i < 8; i++)
      sha_block[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      word.digest_word = sha_chain[i];
      word.word_index  = 3'(i);
      word.last_word   = (3'(i) == WORD_IDX_LAST);
      digest_words_due.push_back(word);
    end
    load_initial_chain();
    sha_fill = 0;
    sha_bytes = '0;
  endfunction

  function automatic void predict_item(msg_t m);
    case (m.command)
      CMD_ABSORB: begin
        absorb_byte(m.data_byte);
      end
      CMD_ABSORB_FINISH: begin
        absorb_byte(m.data_byte);
        finish_message();
      end
      CMD_FINISH: begin
        finish_message();
      end
      default: begin
        // unused code: no state change, no output
      end
    endcase
  endfunction

  initial begin
    load_initial_chain();
    sha_fill = 0;
    sha_bytes = '0;
  end

  // ---------------------------------------------------------------------------
  // message side: one item per call, random idle cycles ahead of it
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
    msg_t m;
    m.command = cmd;
    m.data_byte = data;
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    // stall is read at the edge, before the engine updates it
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    predict_item(m);
    if (cmd == CMD_UNUSED) ignored_items++;
    else message_items++;
  endtask

  // one message of the given length; the finish rides on the last byte or
  // comes as its own item, and unused codes are sprinkled in as noise
  task automatic send_message(input int len);
    bit joined;
    logic [1:0] cmd;
    joined = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) send_item(CMD_UNUSED, 8'($urandom));
      cmd = (joined && i == len - 1) ? CMD_ABSORB_FINISH : CMD_ABSORB;
      send_item(cmd, 8'($urandom));
    end
    // the byte riding with a bare finish is ignored, so it is random too
    if (!joined) send_item(CMD_FINISH, 8'($urandom));
    messages_sent++;
  endtask

  // mostly short messages, a good share around the one-block boundary
  // (where late padding happens) and a few that span two or three blocks
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(0, 8);
    if (r < 70) return $urandom_range(50, 66);
    if (r < 90) return $urandom_range(9, 49);
    return $urandom_range(110, 130);
  endfunction

  // ---------------------------------------------------------------------------
  // digest side: random stall, every accepted word checked in order
  // ---------------------------------------------------------------------------

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t digest %s mismatch: expected %h, actual %h", $time, name, want, got);
    error_count++;
  endfunction

  always @(posedge clk) begin
    if (!rst && digest_valid === 1'b1 && digest_stall === 1'b0) begin
      if (digest_words_due.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual %h index %0d last %0b",
                 $time, digest.digest_word, digest.word_index, digest.last_word);
        error_count++;
      end else begin
        automatic digest_t want = digest_words_due.pop_front();
        if (digest.digest_word !== want.digest_word)
          report_field("digest_word", want.digest_word, digest.digest_word);
        if (digest.word_index !== want.word_index)
          report_field("word_index", 32'(want.word_index), 32'(digest.word_index));
        if (digest.last_word !== want.last_word)
          report_field("last_word", 32'(want.last_word), 32'(digest.last_word));
        words_checked++;
      end
    end
    digest_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // hang detection: count cycles in which no item moves anywhere
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (digest_valid && !digest_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t no progress for %0d cycles, %0d digest words outstanding",
             $time, QUIET_LIMIT, digest_words_due.size());
    $display("sha1_hash_engine_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty message, twice in a row; the byte on a bare finish is ignored
  task automatic test_empty_message();
    send_item(CMD_FINISH, 8'hFF);
    send_item(CMD_FINISH, 8'h00);
    messages_sent += 2;
  endtask

  // "abc" with the finish on the last byte, then one-byte messages at the
  // byte extremes
  task automatic test_short_messages();
    send_item(CMD_ABSORB, 8'h61);
    send_item(CMD_ABSORB, 8'h62);
    send_item(CMD_ABSORB_FINISH, 8'h63);
    send_item(CMD_ABSORB_FINISH, 8'h00);
    send_item(CMD_ABSORB_FINISH, 8'hFF);
    messages_sent += 3;
  endtask

  // unused code between bytes of a message and ahead of a bare finish;
  // it must leave the hash untouched and produce nothing
  task automatic test_ignored_command();
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_ABSORB, 8'h61);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_ABSORB, 8'hFF);
    send_item(CMD_UNUSED, 8'h5A);
    send_item(CMD_FINISH, 8'hA5);
    messages_sent++;
  endtask

  // random messages under one flow-control setting; each phase opens with a
  // message long enough that the marker lands in the length field
  task automatic test_flow_phase(input int idle_pct, input int stall_pct, input int budget);
    int first_item;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    first_item = message_items;
    send_message($urandom_range(56, 63));
    while (message_items - first_item < budget)
      send_message(pick_length());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_short_messages();
    test_ignored_command();

    // free run, sender gaps, receiver stalls, then both
    test_flow_phase(0, 0, 70);
    test_flow_phase(67, 0, 70);
    test_flow_phase(0, 67, 70);
    test_flow_phase(23, 23, 70);

    msg_valid <= 1'b0;
    while (digest_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages from %0d hash items plus %0d unused-code items",
             messages_sent, message_items, ignored_items);
    $display("%0d digest words checked across four flow-control phases, %0d errors",
             words_checked, error_count);
    if (error_count == 0)
      $display("sha1_hash_engine_test passed");
    else
      $display("sha1_hash_engine_test failed");
    $finish;
  end

endmodule
